// ===== hdl/mm4_pkg.sv =====
`default_nettype none

package mm4_pkg;

	localparam int MATRIX_DIM_DEF = 4;

	localparam int KIND_W  = 2;
	localparam int INDEX_W = 4;
	localparam int VALUE_W = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_LEFT  = 2'd0,
		KIND_LOAD_RIGHT = 2'd1,
		KIND_COMPUTE    = 2'd2
	} kind_t;

endpackage

`default_nettype wire

// ===== hdl/mm4_req_if.sv =====
`default_nettype none

interface mm4_req_if import mm4_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [INDEX_W-1:0]        element_index;
	logic signed [VALUE_W-1:0] element_value;

	modport source (output valid, kind, element_index, element_value, input ready);
	modport sink   (input valid, kind, element_index, element_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/mm4_res_if.sv =====
`default_nettype none

interface mm4_res_if import mm4_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [INDEX_W-1:0]        product_index;
	logic signed [VALUE_W-1:0] product_value;
	logic                      saturated;
	logic                      last;

	modport source (output valid, product_index, product_value, saturated, last, input ready);
	modport sink   (input valid, product_index, product_value, saturated, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/matrix4x4_multiply_core.sv =====
`default_nettype none
// Square matrix multiply, product = A times B, both held column-major in Q16.16.
// Request channel (req): kind selects load of one A element, load of one B element,
// or compute. A load with an index past the matrix is dropped,
// as is kind 3. A compute request streams every product element on the result channel
// (res) in column-major order, the final one marked by last, saturated set where the
// element was clipped to the 32-bit range.
// Elements come out one at a time from the one shared multiplier, which a microcoded
// sequencer walks through MATRIX_DIM reads and a two-stage drain per element.
// Requests are taken only while the sequencer idles, one per cycle; the last result may
// still wait in the output register while new loads are taken.
// A stalled receiver holds the output register and freezes the sequencer at its emit step.
// Reset returns the sequencer to idle and empties the pipeline; matrix entries are
// undefined until loaded, and every entry must be loaded before a compute.
module matrix4x4_multiply_core import mm4_pkg::*; #(
	parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	mm4_req_if.sink    req,
	mm4_res_if.source  res
);

	localparam int ElemCount = MATRIX_DIM * MATRIX_DIM;
	localparam int AddrW     = $clog2(ElemCount);
	localparam int CntW      = $clog2(MATRIX_DIM);
	localparam int ProdW     = 2 * VALUE_W;
	localparam int AccW      = ProdW + CntW;
	localparam int TotW      = AccW - 16;

	typedef logic [2:0] upc_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_IDLE_WAIT,
		JC_K_MORE,
		JC_OUT_BUSY,
		JC_ELEM_MORE
	} jc_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic emit;
		jc_t  jc;
		upc_t target;
	} ctl_t;

	localparam upc_t U_IDLE = 3'd0;
	localparam upc_t U_READ = 3'd1;
	localparam upc_t U_DR1  = 3'd2;
	localparam upc_t U_DR2  = 3'd3;
	localparam upc_t U_EMIT = 3'd4;
	localparam upc_t U_NEXT = 3'd5;
	localparam upc_t U_RET  = 3'd6;

	// Microprogram: jump to target when the condition holds, else step on.
	function automatic ctl_t ucode(input upc_t pc);
		ctl_t c;
		c = '{accept: 1'b0, rd: 1'b0, emit: 1'b0, jc: JC_ALWAYS, target: U_IDLE};
		unique case (pc)
			U_IDLE: begin
				c.accept = 1'b1;
				c.jc     = JC_IDLE_WAIT;
				c.target = U_IDLE;
			end
			U_READ: begin
				c.rd     = 1'b1;
				c.jc     = JC_K_MORE;
				c.target = U_READ;
			end
			U_DR1:  c.jc = JC_NEXT;
			U_DR2:  c.jc = JC_NEXT;
			U_EMIT: begin
				c.emit   = 1'b1;
				c.jc     = JC_OUT_BUSY;
				c.target = U_EMIT;
			end
			U_NEXT: begin
				c.jc     = JC_ELEM_MORE;
				c.target = U_READ;
			end
			U_RET:  c.jc = JC_ALWAYS;
			default: c.jc = JC_ALWAYS;
		endcase
		return c;
	endfunction

	upc_t upc_q;
	ctl_t ctl;

	logic [CntW-1:0] row_q, col_q, k_q;
	logic            row_last, col_last, k_last;

	logic [VALUE_W-1:0] left_mem  [ElemCount];
	logic [VALUE_W-1:0] right_mem [ElemCount];

	logic signed [VALUE_W-1:0] a_s1, b_s1;
	logic                      rd_s1;
	logic signed [ProdW-1:0]   prod_s2;
	logic                      mac_s2;
	logic signed [AccW-1:0]    acc_q;

	logic [AddrW-1:0] a_addr, b_addr, pos, wr_addr;
	logic             in_range, start, wr_left, wr_right;
	logic             out_busy, emit_fire, jump;

	logic signed [TotW-1:0]    tot;
	logic                      sat;
	logic signed [VALUE_W-1:0] sat_value;

	logic                      res_valid_q;
	logic [INDEX_W-1:0]        res_index_q;
	logic signed [VALUE_W-1:0] res_value_q;
	logic                      res_sat_q, res_last_q;

	assign ctl = ucode(upc_q);

	assign row_last = (row_q == CntW'(MATRIX_DIM - 1));
	assign col_last = (col_q == CntW'(MATRIX_DIM - 1));
	assign k_last   = (k_q == CntW'(MATRIX_DIM - 1));

	assign a_addr = AddrW'(k_q) * AddrW'(MATRIX_DIM) + AddrW'(row_q);
	assign b_addr = AddrW'(col_q) * AddrW'(MATRIX_DIM) + AddrW'(k_q);
	assign pos    = AddrW'(col_q) * AddrW'(MATRIX_DIM) + AddrW'(row_q);

	assign req.ready = ctl.accept;
	assign in_range  = (32'(req.element_index) < 32'(ElemCount));
	assign wr_addr   = AddrW'(req.element_index);
	assign start     = req.valid && ctl.accept && (req.kind == KIND_COMPUTE);
	assign wr_left   = req.valid && ctl.accept && in_range && (req.kind == KIND_LOAD_LEFT);
	assign wr_right  = req.valid && ctl.accept && in_range && (req.kind == KIND_LOAD_RIGHT);

	assign out_busy  = res_valid_q && !res.ready;
	assign emit_fire = ctl.emit && !out_busy;

	always_comb begin
		unique case (ctl.jc)
			JC_NEXT:      jump = 1'b0;
			JC_ALWAYS:    jump = 1'b1;
			JC_IDLE_WAIT: jump = !start;
			JC_K_MORE:    jump = !k_last;
			JC_OUT_BUSY:  jump = out_busy;
			JC_ELEM_MORE: jump = (row_q != '0) || (col_q != '0);
			default:      jump = 1'b1;
		endcase
	end

	// Floor to Q16.16 by dropping the low 16 bits, then clip to 32 bits.
	assign tot       = acc_q[AccW-1:16];
	assign sat       = (|tot[TotW-1:VALUE_W-1]) && !(&tot[TotW-1:VALUE_W-1]);
	assign sat_value = !sat ? tot[VALUE_W-1:0]
		: (tot[TotW-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (wr_left) begin
			left_mem[wr_addr] <= req.element_value;
		end
		if (wr_right) begin
			right_mem[wr_addr] <= req.element_value;
		end
		a_s1    <= left_mem[a_addr];
		b_s1    <= right_mem[b_addr];
		prod_s2 <= a_s1 * b_s1;
		if (start || emit_fire) begin
			acc_q <= '0;
		end else if (mac_s2) begin
			acc_q <= acc_q + AccW'(prod_s2);
		end
		if (emit_fire) begin
			res_index_q <= INDEX_W'(pos);
			res_value_q <= sat_value;
			res_sat_q   <= sat;
			res_last_q  <= row_last && col_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			rd_s1       <= 1'b0;
			mac_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			upc_q  <= jump ? ctl.target : upc_t'(upc_q + 3'd1);
			rd_s1  <= ctl.rd;
			mac_s2 <= rd_s1;
			if (start) begin
				row_q <= '0;
				col_q <= '0;
				k_q   <= '0;
			end else begin
				if (ctl.rd) begin
					k_q <= k_last ? '0 : k_q + 1'b1;
				end
				// advance to the next element, column-major
				if (emit_fire) begin
					row_q <= row_last ? '0 : row_q + 1'b1;
					if (row_last) begin
						col_q <= col_last ? '0 : col_q + 1'b1;
					end
				end
			end
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.product_index = res_index_q;
	assign res.product_value = res_value_q;
	assign res.saturated     = res_sat_q;
	assign res.last          = res_last_q;

endmodule

`default_nettype wire
